[rtl/assert_macros.svh]
// Assertion helpers shared by rcc_ctrl and the top level. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that must hold at every clock edge out of reset.
`define RCC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that forces another one at the following clock edge.
`define RCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rcc_pkg.sv]
// ---------------------------------------------------------------------------
// rcc_pkg
// Types and constants of the 3x3 RGB convolution block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W    = 12;
  localparam int COEF_W   = 16;
  localparam int PIX_W    = 24;
  localparam int PROD_W   = 24;
  localparam int ROW_SUM_W = 26;
  localparam int SUM_W    = 28;
  localparam int KSIZE    = 3;
  localparam int NCH      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

  localparam logic [CFG_W-1:0] KERNEL_TOP_RST = 48'd0;
  localparam logic [CFG_W-1:0] KERNEL_MID_RST = 48'd65536;
  localparam logic [CFG_W-1:0] KERNEL_BOT_RST = 48'd0;

  typedef logic [PIX_W-1:0]          pixel_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ROW_SUM_W-1:0] row_sum_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // What the frame counters decide for one accepted transfer.
  typedef struct packed {
    logic act;        // transfer moves the window and line stores
    logic drain;      // pixel data is replaced by zero
    logic emit;       // a result leaves for this transfer
    logic top_ok;     // row above lies inside the frame
    logic bot_ok;     // row below lies inside the frame
    logic left_ok;    // column to the left lies inside the frame
    logic right_ok;   // column to the right lies inside the frame
    logic frame_end;  // last result of the frame
  } step_ctl_t;

  function automatic logic [7:0] clamp_byte(input sum_t s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s > sum_t'(255)) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rcc_ram.sv]
// ---------------------------------------------------------------------------
// rcc_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/rcc_cell.sv]
// ---------------------------------------------------------------------------
// rcc_cell
// One window cell: holds a pixel, passes it on, and weights its three channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcc_cell (
  input  wire logic           clk,
  input  wire logic           shift_en,
  input  wire rcc_pkg::pixel_t pix_in,
  output rcc_pkg::pixel_t     pix_out,
  input  wire logic           prod_en,
  input  wire rcc_pkg::coef_t coef,
  input  wire logic           in_frame,
  output rcc_pkg::prod_t      prod [rcc_pkg::NCH]
);
  import rcc_pkg::*;

  pixel_t pix_r;
  prod_t  prod_r [NCH];

  assign pix_out = pix_r;
  assign prod    = prod_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= pix_in;
    end
  end

  // Channel 0 is the top byte, which the top level fills with blue; a cell outside the frame adds zero.
  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    always_ff @(posedge clk) begin
      if (prod_en) begin
        if (in_frame) begin
          prod_r[ch] <= prod_t'(coef) * prod_t'($signed({1'b0, pix_r[PIX_W-1-8*ch -: 8]}));
        end else begin
          prod_r[ch] <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rcc_ctrl.sv]
// ---------------------------------------------------------------------------
// rcc_ctrl
// Input and output raster counters, border flags and frame end detection.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rcc_ctrl #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire logic                         func,
  input  wire logic                         restart,
  input  wire logic [rcc_pkg::DIM_W-1:0]    frame_width,
  input  wire logic [rcc_pkg::DIM_W-1:0]    frame_height,
  output rcc_pkg::step_ctl_t                ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]      col
);
  import rcc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic             all_in_r, all_in_nxt;
  int unsigned      ew, eh;
  logic             col_last, row_last, ocol_last, orow_last;

  always_comb begin
    if (frame_width == '0) begin
      ew = 1;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      ew = MAX_WIDTH;
    end else begin
      ew = 32'(frame_width);
    end
    if (frame_height == '0) begin
      eh = 1;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      eh = MAX_HEIGHT;
    end else begin
      eh = 32'(frame_height);
    end
  end

  assign col_last  = (32'(in_col_r) + 1 >= ew);
  assign row_last  = (32'(in_row_r) + 1 >= eh);
  assign ocol_last = (32'(out_col_r) + 1 >= ew);
  assign orow_last = (32'(out_row_r) + 1 >= eh);
  assign col       = in_col_r;

  always_comb begin
    ctl.act       = fire && !(func && !all_in_r);
    ctl.drain     = all_in_r;
    // The result lags by one row plus one pixel.
    ctl.emit      = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    ctl.top_ok    = (out_row_r != '0);
    ctl.bot_ok    = !orow_last;
    ctl.left_ok   = (out_col_r != '0);
    ctl.right_ok  = !ocol_last;
    ctl.frame_end = orow_last && ocol_last;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    all_in_nxt  = all_in_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      all_in_nxt  = 1'b0;
    end else if (ctl.act) begin
      if (!all_in_r && row_last && col_last) begin
        all_in_nxt = 1'b1;
      end
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (ctl.emit) begin
        if (ctl.frame_end) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          all_in_nxt  = 1'b0;
        end else if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      all_in_r  <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      all_in_r  <= all_in_nxt;
    end
  end

  `RCC_ASSERT_NEXT(a_frame_end_clears, ctl.act && ctl.emit && ctl.frame_end && !restart, in_col_r == '0 && in_row_r == '0 && !all_in_r, "frame end did not clear counters")
  `RCC_ASSERT_ALWAYS(a_emit_before_all_out, !(ctl.act && ctl.emit) || !all_in_r || in_row_r != '0, "drain before first result")

endmodule

`default_nettype wire

[rtl/rgb_conv3x3_zero_pad_clamp.sv]
// ---------------------------------------------------------------------------
// rgb_conv3x3_zero_pad_clamp
// Streaming 3x3 convolution of RGB pixels with zero padding and 0..255 clamp.
// ---------------------------------------------------------------------------
// One transfer is accepted per clock while the output side keeps up. Each
// result passes the numbered stages and the output register after the transfer
// that completes its window, and lags the input raster by frame_width+1
// positions; frame_width+1 drain ticks (tuser high) after the last pixel flush
// the rest, and tlast marks the last result of a frame. Two line RAMs with
// registered reads feed a 3x3 grid of window cells that weight their pixels;
// two adder stages then sum and clamp. Line RAMs hold no defined data after
// reset; border masking never uses them before they are written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rgb_conv3x3_zero_pad_clamp #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,   // red_in, green_in, blue_in
  input  wire logic                          in_tuser,   // func
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [23:0]                        out_tdata,  // red_out, green_out, blue_out
  output logic                               out_tlast,
  input  wire logic                          cfg_we,
  input  wire logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rcc_pkg::CFG_W-1:0]     cfg_data
);
  import rcc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [DIM_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] kern_r [KSIZE];
  logic             restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(2048);
      height_r  <= DIM_W'(2048);
      kern_r[0] <= KERNEL_TOP_RST;
      kern_r[1] <= KERNEL_MID_RST;
      kern_r[2] <= KERNEL_BOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r  <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:   kern_r[0] <= cfg_data;
        REG_KERNEL_MID:   kern_r[1] <= cfg_data;
        REG_KERNEL_BOT:   kern_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  // The whole pipeline moves whenever the output register is free.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  step_ctl_t        ctl;
  logic [COL_W-1:0] col;

  rcc_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk, .rst_n,
    .fire        (in_tvalid && en),
    .func        (in_tuser),
    .restart,
    .frame_width (width_r),
    .frame_height(height_r),
    .ctl,
    .col
  );

  // Stage 1: line RAM read data arrives.
  logic             v1_r;
  step_ctl_t        c1_r;
  logic [COL_W-1:0] col1_r;
  pixel_t           pix1_r;
  pixel_t           up_rd, lo_rd, up_eff, lo_eff;
  logic             fwd_r;
  pixel_t           fwd_up_r, fwd_lo_r;
  logic             wr1;

  assign wr1 = en && v1_r;

  rcc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk, .we(wr1), .waddr(col1_r), .wdata(lo_eff),
    .re(en), .raddr(col), .rdata(up_rd)
  );
  rcc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk, .we(wr1), .waddr(col1_r), .wdata(pix1_r),
    .re(en), .raddr(col), .rdata(lo_rd)
  );

  // A one-pixel-wide frame reads the column written in the same cycle.
  assign up_eff = fwd_r ? fwd_up_r : up_rd;
  assign lo_eff = fwd_r ? fwd_lo_r : lo_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else if (en) begin
      v1_r  <= ctl.act;
      fwd_r <= ctl.act && v1_r && (col == col1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= ctl;
      col1_r   <= col;
      pix1_r   <= ctl.drain ? '0 : {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      fwd_up_r <= lo_eff;
      fwd_lo_r <= pix1_r;
    end
  end

  // Stage 2: window cells hold the neighborhood, stage 3: weighted products.
  logic      v2_r, v3_r, v4_r;
  step_ctl_t c2_r, c3_r, c4_r;
  pixel_t    col_in [KSIZE];
  pixel_t    pix_o  [KSIZE][KSIZE];
  prod_t     prod   [KSIZE][KSIZE][NCH];
  logic      row_ok [KSIZE];
  logic      col_ok [KSIZE];

  assign col_in[0] = up_eff;
  assign col_in[1] = lo_eff;
  assign col_in[2] = pix1_r;
  assign row_ok[0] = c2_r.top_ok;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = c2_r.bot_ok;
  assign col_ok[0] = c2_r.left_ok;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = c2_r.right_ok;

  for (genvar r = 0; r < KSIZE; r++) begin : g_row
    for (genvar c = 0; c < KSIZE; c++) begin : g_col
      rcc_cell u_cell (
        .clk,
        .shift_en(wr1),
        .pix_in  ((c == KSIZE - 1) ? col_in[r] : pix_o[r][(c + 1) % KSIZE]),
        .pix_out (pix_o[r][c]),
        .prod_en (en),
        .coef    (coef_t'(kern_r[r][COEF_W*c +: COEF_W])),
        .in_frame(row_ok[r] && col_ok[c]),
        .prod    (prod[r][c])
      );
    end
  end

  // Stage 4: row sums, then total and clamp into the output register.
  row_sum_t rsum_r [KSIZE][NCH];
  sum_t     total  [NCH];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < KSIZE; r++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          rsum_r[r][ch] <= ROW_SUM_W'(prod[r][0][ch]) + ROW_SUM_W'(prod[r][1][ch])
                         + ROW_SUM_W'(prod[r][2][ch]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      total[ch] = SUM_W'(rsum_r[0][ch]) + SUM_W'(rsum_r[1][ch]) + SUM_W'(rsum_r[2][ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v2_r       <= v1_r && c1_r.emit;
      v3_r       <= v2_r;
      v4_r       <= v3_r;
      out_tvalid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r      <= c1_r;
      c3_r      <= c2_r;
      c4_r      <= c3_r;
      out_tlast <= c4_r.frame_end;
      out_tdata <= {clamp_byte(total[2]), clamp_byte(total[1]), clamp_byte(total[0])};
    end
  end

  `RCC_ASSERT_ALWAYS(a_fwd_needs_item, !fwd_r || v1_r, "forwarding without an item in flight")
  `RCC_ASSERT_NEXT(a_result_reaches_out, v4_r && en, out_tvalid, "result lost before output")
  `RCC_ASSERT_NEXT(a_ignored_tick_idle, in_tvalid && en && !ctl.act, !v1_r, "ignored tick entered pipe")

endmodule

`default_nettype wire
